@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the RTL back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked on every rising clock edge outside reset.
`define PLM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every rising clock edge outside reset.
`define PLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hw/rtl/plm_pkg.sv @@
// Types and constants shared by the likelihood chi-square modules.
package plm_pkg;
  localparam int unsigned FracBits = 16;
  localparam int unsigned MaxBins  = 256;
  localparam int unsigned BinW     = 9;
  localparam int unsigned LogFrac  = 28;
  localparam logic [27:0] Ln2Q28   = 28'd186065280;
  localparam logic [47:0] SumMax   = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OpNone,
    OpAddV,
    OpLog
  } op_e;

  typedef struct packed {
    logic [31:0] predicted;
    logic [15:0] observed;
    logic        last;
  } in_req_t;

  typedef struct packed {
    logic [47:0] statistic;
    logic        saturated;
  } out_req_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] predicted;
    logic [15:0] observed;
    logic        last;
  } cmd_t;
endpackage

@@ hw/rtl/poisson_likelihood_chi_square.sv @@
// Top level of the Poisson likelihood-ratio chi-square block.
// Each input request carries one histogram bin: a predicted count in unsigned
// Q16.16, an observed integer count and a last-bin flag. Bins below the
// first_bin register (APB address 0, reset 1) add nothing to the sum.
// A request is taken when in_valid_i is high and in_stall_o is low; a two-entry
// queue feeds the arithmetic unit, so requests are taken while it works.
// An included bin with a positive prediction and a nonzero count passes the
// log unit, which squares both mantissas once per cycle for 28 bits, then the
// ln, product and term steps; other bins go straight to the sum. On the last
// bin one result request is registered onto out_valid_o after its bin ends;
// it carries twice the sum in Q32.16 and a saturation flag, and the sum then
// restarts at zero. While out_stall_i is high the result holds, and a later
// last bin waits. Reset clears the sum, queue and out_valid_o; bins count from 1.
module poisson_likelihood_chi_square (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [0:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  input  plm_pkg::in_req_t    in_req_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output plm_pkg::out_req_t   out_req_o,
  input  logic                out_stall_i
);
  logic [7:0]     first_bin_q, first_bin_d;
  logic           cmd_valid;
  plm_pkg::cmd_t  cmd;
  logic           cmd_pop;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {24'd0, first_bin_q} : 32'd0;

  always_comb begin
    first_bin_d = first_bin_q;
    if (psel && penable && pwrite && (paddr == 1'b0)) begin
      first_bin_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_bin_q <= 8'd1;
    end else begin
      first_bin_q <= first_bin_d;
    end
  end

  plm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .first_bin_i (first_bin_q),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_stall_o  (in_stall_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  plm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_req_o   (out_req_o),
    .out_stall_i (out_stall_i)
  );
endmodule

@@ hw/rtl/plm_front.sv @@
// Front end: accepts bins, numbers and classifies them, and queues commands.
module plm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          first_bin_i,
  input  logic                in_valid_i,
  input  plm_pkg::in_req_t    in_req_i,
  output logic                in_stall_o,
  output logic                cmd_valid_o,
  output plm_pkg::cmd_t       cmd_o,
  input  logic                cmd_pop_i
);
  plm_pkg::cmd_t                fifo_q [2];
  logic                         wr_ptr_q, wr_ptr_d;
  logic                         rd_ptr_q, rd_ptr_d;
  logic [1:0]                   cnt_q, cnt_d;
  logic [plm_pkg::BinW-1:0]     bin_q, bin_d;
  logic                         push;
  logic                         incl;
  plm_pkg::cmd_t                cmd_new;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  assign incl = (bin_q >= {1'b0, first_bin_i});

  always_comb begin
    cmd_new.predicted = in_req_i.predicted;
    cmd_new.observed  = in_req_i.observed;
    cmd_new.last      = in_req_i.last;
    if (!incl || (in_req_i.predicted == 32'd0)) begin
      cmd_new.op = plm_pkg::OpNone;
    end else if (in_req_i.observed == 16'd0) begin
      cmd_new.op = plm_pkg::OpAddV;
    end else begin
      cmd_new.op = plm_pkg::OpLog;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    bin_d    = bin_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
      if (in_req_i.last) begin
        bin_d = plm_pkg::BinW'(1);
      end else if (bin_q < plm_pkg::BinW'(plm_pkg::MaxBins)) begin
        bin_d = bin_q + plm_pkg::BinW'(1);
      end
    end
    if (cmd_pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    cnt_d = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      bin_q    <= plm_pkg::BinW'(1);
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      bin_q    <= bin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end
endmodule

@@ hw/rtl/plm_back.sv @@
// Back end: iterative log unit, deviance term, accumulator and result register.
`include "assert_macros.svh"
module plm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  plm_pkg::cmd_t       cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  output plm_pkg::out_req_t   out_req_o,
  input  logic                out_stall_i
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SLog  = 3'd1;
  localparam logic [2:0] SLn   = 3'd2;
  localparam logic [2:0] SNl   = 3'd3;
  localparam logic [2:0] STerm = 3'd4;
  localparam logic [2:0] SAcc  = 3'd5;

  function automatic logic [4:0] lead_one(logic [31:0] x);
    logic [4:0] k;
    k = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        k = 5'(i);
      end
    end
    return k;
  endfunction

  function automatic logic [28:0] mant(logic [31:0] x, logic [4:0] k);
    logic [31:0] xs;
    xs = x << (5'd31 - k);
    return xs[31:3];
  endfunction

  logic [2:0]          state_q, state_d;
  plm_pkg::cmd_t       cmd_q, cmd_d;
  logic [28:0]         ma_q, ma_d, mb_q, mb_d;
  logic [32:0]         ra_q, ra_d, rb_q, rb_d;
  logic [4:0]          it_q, it_d;
  logic [32:0]         p_q, p_d;
  logic                neg_q, neg_d;
  logic signed [50:0]  prod_q, prod_d;
  logic [47:0]         term_q, term_d;
  logic [47:0]         sum_q, sum_d;
  logic                ovf_q, ovf_d;
  logic                out_valid_q, out_valid_d;
  plm_pkg::out_req_t   out_q, out_d;

  logic [31:0]         xa;
  logic [4:0]          ka, kb;
  logic [57:0]         sqa, sqb;
  logic [29:0]         m2a, m2b;
  logic signed [33:0]  dlog;
  logic [32:0]         mag;
  logic [60:0]         lnprod;
  logic signed [33:0]  lnq;
  logic signed [16:0]  ns;
  logic signed [52:0]  t;
  logic [51:0]         tr;
  logic [48:0]         s;
  logic [47:0]         s_c;
  logic                ovf_n;
  logic [48:0]         st;
  logic                out_free;

  assign xa  = {cmd_i.observed, 16'd0};
  assign ka  = lead_one(xa);
  assign kb  = lead_one(cmd_i.predicted);
  assign sqa = 58'(ma_q) * 58'(ma_q);
  assign sqb = 58'(mb_q) * 58'(mb_q);
  assign m2a = sqa[57:28];
  assign m2b = sqb[57:28];

  assign dlog   = $signed({1'b0, ra_q}) - $signed({1'b0, rb_q});
  assign mag    = dlog[33] ? 33'(-dlog) : dlog[32:0];
  assign lnprod = 61'(mag) * 61'(plm_pkg::Ln2Q28) + 61'(1 << 27);

  assign lnq = neg_q ? -$signed({1'b0, p_q}) : $signed({1'b0, p_q});
  assign ns  = $signed({1'b0, cmd_q.observed});

  assign t  = $signed({9'd0, cmd_q.predicted, 12'd0})
            - $signed({9'd0, cmd_q.observed, 28'd0})
            + $signed({{2{prod_q[50]}}, prod_q});
  assign tr = t[51:0] + 52'd2048;

  assign s     = {1'b0, sum_q} + {1'b0, term_q};
  assign s_c   = s[48] ? plm_pkg::SumMax : s[47:0];
  assign ovf_n = ovf_q || s[48] || (s_c == plm_pkg::SumMax);
  assign st    = {s_c, 1'b0};

  assign out_free    = !out_valid_q || !out_stall_i;
  assign cmd_pop_o   = (state_q == SIdle) && cmd_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    it_d        = it_q;
    p_d         = p_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    term_d      = term_q;
    sum_d       = sum_q;
    ovf_d       = ovf_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      SIdle: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          ma_d  = mant(xa, ka);
          mb_d  = mant(cmd_i.predicted, kb);
          ra_d  = {ka, 28'd0};
          rb_d  = {kb, 28'd0};
          it_d  = 5'd27;
          case (cmd_i.op)
            plm_pkg::OpLog: begin
              state_d = SLog;
            end
            plm_pkg::OpAddV: begin
              term_d  = {16'd0, cmd_i.predicted};
              state_d = SAcc;
            end
            default: begin
              term_d  = 48'd0;
              state_d = SAcc;
            end
          endcase
        end
      end
      SLog: begin
        if (m2a[29]) begin
          ma_d = m2a[29:1];
          ra_d = ra_q | (33'd1 << it_q);
        end else begin
          ma_d = m2a[28:0];
        end
        if (m2b[29]) begin
          mb_d = m2b[29:1];
          rb_d = rb_q | (33'd1 << it_q);
        end else begin
          mb_d = m2b[28:0];
        end
        it_d = it_q - 5'd1;
        if (it_q == 5'd0) begin
          state_d = SLn;
        end
      end
      SLn: begin
        p_d     = lnprod[60:28];
        neg_d   = dlog[33];
        state_d = SNl;
      end
      SNl: begin
        prod_d  = ns * lnq;
        state_d = STerm;
      end
      STerm: begin
        if (t[52] || (t == 53'sd0)) begin
          term_d = 48'd0;
        end else begin
          term_d = 48'(tr[51:12]);
        end
        state_d = SAcc;
      end
      SAcc: begin
        if (!cmd_q.last) begin
          sum_d   = s_c;
          ovf_d   = ovf_n;
          state_d = SIdle;
        end else if (out_free) begin
          out_d.statistic = st[48] ? plm_pkg::SumMax : st[47:0];
          out_d.saturated = ovf_n || st[48];
          out_valid_d     = 1'b1;
          sum_d           = 48'd0;
          ovf_d           = 1'b0;
          state_d         = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      sum_q       <= 48'd0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    it_q   <= it_d;
    p_q    <= p_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    term_q <= term_d;
    out_q  <= out_d;
  end

  `PLM_ASSERT_IMP(a_ovf_sum, ovf_q, sum_q == plm_pkg::SumMax, "Overflow flag without full sum.")
  `PLM_ASSERT_IMP(a_even, out_valid_q && !out_q.saturated, out_q.statistic[0] == 1'b0, "Odd result.")
  `PLM_ASSERT_NEXT(a_log_end, (state_q == SLog) && (it_q == 5'd0), state_q == SLn, "Log overrun.")
endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the Poisson likelihood-ratio chi-square block.
`timescale 1ns / 100ps

module tb;
  localparam logic [47:0] SatMax = 48'hFFFF_FFFF_FFFF;
  localparam int unsigned Limit = 2000000;
  localparam int unsigned DrainCycles = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [0:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  plm_pkg::in_req_t in_req_i = '0;
  logic in_stall_o;
  logic out_valid_o;
  plm_pkg::out_req_t out_req_o;
  logic out_stall_i = 1'b0;
  logic in_taken = 1'b0;

  plm_pkg::in_req_t bin_queue[$];
  plm_pkg::out_req_t stat_queue[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned bins_sent = 0;
  int unsigned stats_seen = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  logic [7:0] first_bin_m;
  logic [47:0] dev_sum_m;
  logic [8:0] bin_no_m;
  logic ovf_m;

  poisson_likelihood_chi_square u_top (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint log2_q28(longint unsigned x);
    int k;
    longint unsigned m;
    longint r;
    k = 63;
    while (k > 0 && x[k] == 1'b0) k--;
    if (k >= plm_pkg::LogFrac) m = x >> (k - plm_pkg::LogFrac);
    else m = x << (plm_pkg::LogFrac - k);
    r = longint'(k) <<< plm_pkg::LogFrac;
    for (int i = plm_pkg::LogFrac - 1; i >= 0; i--) begin
      m = (m * m) >> plm_pkg::LogFrac;
      if (m >= (64'd2 << plm_pkg::LogFrac)) begin
        m = m >> 1;
        r += longint'(1) <<< i;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned deviance_term(longint unsigned v, longint unsigned n);
    longint vq, d, lnq, t;
    longint unsigned mag, p;
    vq = longint'(v << (plm_pkg::LogFrac - plm_pkg::FracBits));
    if (n == 0) return v;
    d = log2_q28(n << plm_pkg::FracBits) - log2_q28(v);
    mag = (d < 0) ? longint'(-d) : longint'(d);
    p = (mag * 64'd186065280 + (64'd1 << (plm_pkg::LogFrac - 1))) >> plm_pkg::LogFrac;
    lnq = (d < 0) ? -longint'(p) : longint'(p);
    t = (vq - longint'(n << plm_pkg::LogFrac)) + longint'(n) * lnq;
    if (t <= 0) return 0;
    return (longint'(t) + (64'd1 << (plm_pkg::LogFrac - plm_pkg::FracBits - 1)))
           >> (plm_pkg::LogFrac - plm_pkg::FracBits);
  endfunction

  task automatic predict_bin(input plm_pkg::in_req_t b);
    longint unsigned s, st;
    plm_pkg::out_req_t r;
    if (bin_no_m >= first_bin_m && b.predicted != 0) begin
      s = dev_sum_m + deviance_term(b.predicted, b.observed);
      if (s >= SatMax) begin
        s = SatMax;
        ovf_m = 1'b1;
      end
      dev_sum_m = s[47:0];
    end
    if (bin_no_m < plm_pkg::MaxBins) bin_no_m++;
    if (b.last) begin
      st = longint'(dev_sum_m) * 2;
      r.saturated = ovf_m;
      if (st > SatMax) begin
        st = SatMax;
        r.saturated = 1'b1;
      end
      r.statistic = st[47:0];
      stat_queue.push_back(r);
      dev_sum_m = '0;
      bin_no_m = 9'd1;
      ovf_m = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("Mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Acceptance is seen at the rising edge, where the handshake takes place.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_bin(in_req_i);
      bins_sent++;
    end
  end

  // Driver: offers queued bins at the falling edge, holding each until taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken || !in_valid_i) begin
        if (bin_queue.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
          in_req_i <= bin_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      stats_seen++;
      if (stat_queue.size() == 0) begin
        report_mismatch("unexpected result", out_req_o, 0);
      end else begin
        if (out_req_o.statistic != stat_queue[0].statistic)
          report_mismatch("statistic", out_req_o.statistic, stat_queue[0].statistic);
        if (out_req_o.saturated != stat_queue[0].saturated)
          report_mismatch("saturated", out_req_o.saturated, stat_queue[0].saturated);
        void'(stat_queue.pop_front());
      end
    end
  end

  task automatic write_first_bin(input logic [7:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {24'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    first_bin_m = value;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    while (bin_queue.size() != 0 || in_valid_i || stat_queue.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic plm_pkg::in_req_t random_bin(input bit last);
    plm_pkg::in_req_t b;
    int unsigned sel;
    sel = $urandom_range(9, 0);
    case (sel)
      0: b.predicted = 32'd0;
      1: b.predicted = 32'hFFFF_FFFF;
      2: b.predicted = $urandom;
      default: b.predicted = $urandom_range(32'h0040_0000, 32'h0000_0100);
    endcase
    sel = $urandom_range(9, 0);
    case (sel)
      0: b.observed = 16'd0;
      1: b.observed = 16'hFFFF;
      2: b.observed = 16'($urandom);
      default: b.observed = 16'($urandom_range(64, 0));
    endcase
    b.last = last;
    return b;
  endfunction

  task automatic queue_histogram(input int unsigned nbins);
    for (int unsigned i = 1; i <= nbins; i++) bin_queue.push_back(random_bin(i == nbins));
  endtask

  initial begin
    int unsigned phase_bins;
    first_bin_m = 8'd1;
    dev_sum_m = '0;
    bin_no_m = 9'd1;
    ovf_m = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed bins: zeros, extremes, equal prediction and count, large deviance terms.
    bin_queue.push_back('{32'd0, 16'd5, 1'b0});
    bin_queue.push_back('{32'h0001_0000, 16'd0, 1'b0});
    bin_queue.push_back('{32'h0005_0000, 16'd5, 1'b0});
    bin_queue.push_back('{32'h0000_0001, 16'hFFFF, 1'b0});
    bin_queue.push_back('{32'hFFFF_FFFF, 16'd1, 1'b1});
    bin_queue.push_back('{32'd0, 16'd0, 1'b1});
    for (int i = 0; i < 8; i++) bin_queue.push_back('{32'h0000_0001, 16'hFFFF, i == 7});
    bin_queue.push_back('{32'h0000_0001, 16'hFFFF, 1'b1});
    wait_idle();
    // A histogram longer than the bin counter range.
    for (int i = 0; i < 300; i++) bin_queue.push_back('{32'h0000_8000, 16'd0, i == 299});
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 80; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 80; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      case (ph)
        0: write_first_bin(8'd0);
        1: write_first_bin(8'd255);
        2: write_first_bin(8'd1);
        3: write_first_bin(8'd3);
        default: write_first_bin(8'($urandom_range(6, 0)));
      endcase
      phase_bins = 0;
      while (phase_bins < 70) begin
        queue_histogram($urandom_range(6, 1));
        phase_bins = bin_queue.size() + phase_bins;
        while (bin_queue.size() != 0) @(posedge clk_i);
      end
      wait_idle();
    end
    idle_pct = 0;
    stall_pct = 0;

    $display("Sent %0d bins and checked %0d statistics over eight idling phases", bins_sent,
             stats_seen);
    $display("first_bin settings covered 0, 1, 3, 255 and random small values");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/plm_pkg.sv
hw/rtl/plm_front.sv
hw/rtl/plm_back.sv
hw/rtl/poisson_likelihood_chi_square.sv
tb/sv/tb.sv
